// ===== sv/lcg48_pkg.sv =====
// ----------------------------------------------------------------------------
// lcg48_pkg
// Shared types and constants for the 48-bit linear congruential generator:
// command codes, item structures and the interfaces of the multiply unit and
// the remainder unit.
// ----------------------------------------------------------------------------
package lcg48_pkg;

  localparam int unsigned STATE_W     = 48;
  localparam int unsigned MUL_DIGIT_W = 16;
  localparam int unsigned MUL_STEPS   = STATE_W / MUL_DIGIT_W;
  localparam int unsigned REM_W       = 31;

  localparam logic [STATE_W-1:0] LCG_MUL = 48'h0005_DEEC_E66D;
  localparam logic [STATE_W-1:0] LCG_ADD = 48'h0000_0000_000B;

  // Inverse of the multiplier modulo 2^48, by Newton iteration at elaboration.
  function automatic logic [STATE_W-1:0] calc_mul_inv(input logic [63:0] m);
    logic [63:0] x;
    x = m;
    for (int i = 0; i < 6; i++) begin
      x = x * (64'd2 - m * x);
    end
    return x[STATE_W-1:0];
  endfunction

  localparam logic [STATE_W-1:0] LCG_MUL_INV = calc_mul_inv(64'(LCG_MUL));

  typedef enum logic [2:0] {
    CMD_RESEED  = 3'd0,
    CMD_INT     = 3'd1,
    CMD_LONG    = 3'd2,
    CMD_BOUNDED = 3'd3,
    CMD_FLOAT   = 3'd4,
    CMD_DOUBLE  = 3'd5,
    CMD_FWD     = 3'd6,
    CMD_INV     = 3'd7
  } cmd_e;

  typedef struct packed {
    cmd_e               command;
    logic signed [63:0] seed_value;
    logic signed [31:0] bound;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               bad_bound;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic               sel_inv;
    logic [STATE_W-1:0] a;
    logic [STATE_W-1:0] addend;
  } mac_req_t;

  typedef struct packed {
    logic               done;
    logic [STATE_W-1:0] result;
  } mac_rsp_t;

  typedef struct packed {
    logic             start;
    logic [REM_W-1:0] dividend;
    logic [REM_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [REM_W-1:0] remainder;
  } rem_rsp_t;

endpackage

// ===== sv/lcg48_mac.sv =====
// ----------------------------------------------------------------------------
// lcg48_mac
// Multiply-accumulate unit: a * C + addend modulo 2^48, where C is the LCG
// multiplier or its inverse, taken one 16-bit digit of C per cycle.
// ----------------------------------------------------------------------------
module lcg48_mac (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lcg48_pkg::mac_req_t req_i,
  output lcg48_pkg::mac_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(lcg48_pkg::MUL_STEPS);

  logic [lcg48_pkg::STATE_W-1:0] acc_q, acc_d;
  logic [lcg48_pkg::STATE_W-1:0] a_q, a_d;
  logic [lcg48_pkg::STATE_W-1:0] c_q, c_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [lcg48_pkg::STATE_W-1:0] prod;

  // One 48 x 16 partial product per cycle, already shifted into place.
  assign prod = a_q * lcg48_pkg::STATE_W'(c_q[lcg48_pkg::MUL_DIGIT_W-1:0]);

  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    c_d    = c_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      acc_d  = req_i.addend;
      a_d    = req_i.a;
      c_d    = req_i.sel_inv ? lcg48_pkg::LCG_MUL_INV : lcg48_pkg::LCG_MUL;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = acc_q + prod;
      a_d   = a_q << lcg48_pkg::MUL_DIGIT_W;
      c_d   = c_q >> lcg48_pkg::MUL_DIGIT_W;
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(lcg48_pkg::MUL_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    c_q   <= c_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = acc_q;

endmodule

// ===== sv/lcg48_rem.sv =====
// ----------------------------------------------------------------------------
// lcg48_rem
// Restoring remainder unit for 31-bit operands, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcg48_rem (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lcg48_pkg::rem_req_t req_i,
  output lcg48_pkg::rem_rsp_t rsp_o
);

  localparam int unsigned W    = lcg48_pkg::REM_W;
  localparam int unsigned CntW = $clog2(W);

  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    dvd_q, dvd_d;
  logic [W-1:0]    dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [W:0]      trial;
  logic [W:0]      diff;

  assign trial = {rem_q, dvd_q[W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // The partial remainder stays below the divisor, so W bits hold it.
      rem_d = diff[W] ? trial[W-1:0] : diff[W-1:0];
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== sv/lcg48_random_generator_top.sv =====
// ----------------------------------------------------------------------------
// lcg48_random_generator_top
// 48-bit linear congruential random number generator with command items.
// ----------------------------------------------------------------------------
// The block keeps a 48-bit state that advances as state * 0x5DEECE66D + 0xB
// modulo 2^48, and returns exactly one result item for every command item.
// It works on one item at a time: the input is stalled from acceptance until
// the result has been placed in the output register, and a new item may be
// accepted while that result still waits to be taken. Every state advance
// goes through one shared multiply unit that takes one 16-bit digit of the
// constant per cycle. A reseed, or a bounded request with a bound of zero or
// less, does not use the multiply unit; an int, float or valid bounded draw
// advances the state through it, long and double advance it with a second
// step as well, and the pure step commands use it without keeping the
// product as state. A power-of-two bound scales the draw; any other bound
// adds a serial remainder of 31 steps, and every rejected draw adds another
// state step and remainder, which makes that command's latency data
// dependent. The state is zero after reset and changes only on reseed and
// the random draw commands.
// ----------------------------------------------------------------------------
module lcg48_random_generator_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lcg48_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lcg48_pkg::out_item_t out_item_o
);

  localparam int unsigned SW = lcg48_pkg::STATE_W;
  localparam int unsigned RW = lcg48_pkg::REM_W;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } fsm_e;

  // Bit position of a one-hot word; used for power-of-two bounds.
  function automatic logic [4:0] onehot_index(input logic [RW-1:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int i = 0; i < RW; i++) begin
      if (v[i]) begin
        idx = idx | 5'(i);
      end
    end
    return idx;
  endfunction

  fsm_e                 state_q, state_d;
  lcg48_pkg::cmd_e      cmd_q, cmd_d;
  logic [SW-1:0]        lcg_state_q, lcg_state_d;
  logic [RW-1:0]        bound_q, bound_d;
  logic                 second_q, second_d;
  logic [31:0]          hi_q, hi_d;
  logic [RW-1:0]        u_q, u_d;
  logic [63:0]          res_val_q, res_val_d;
  logic                 res_bad_q, res_bad_d;
  lcg48_pkg::out_item_t out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  lcg48_pkg::mac_req_t  mac_req;
  lcg48_pkg::mac_rsp_t  mac_rsp;
  lcg48_pkg::rem_req_t  rem_req;
  lcg48_pkg::rem_rsp_t  rem_rsp;

  logic [SW-1:0]        step;
  logic [RW-1:0]        draw31;
  logic                 bound_pow2;
  logic [4:0]           pow2_shift;
  logic [31:0]          reject_chk;

  lcg48_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .rsp_o  (mac_rsp)
  );

  lcg48_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  // The fresh state from the multiply unit, and the 31-bit draw taken from it.
  assign step   = mac_rsp.result;
  assign draw31 = step[SW-1:SW-RW];

  // For a power-of-two bound 2^k, (bound * r) >> 31 is simply r >> (31 - k).
  assign bound_pow2 = (bound_q & (bound_q - RW'(1))) == '0;
  assign pow2_shift = 5'(RW) - onehot_index(bound_q);

  // Rejection test of the modulo path: u - r + (bound - 1) must not reach 2^31.
  assign reject_chk = {1'b0, u_q} - {1'b0, rem_rsp.remainder} + {1'b0, bound_q - RW'(1)};

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    lcg_state_d = lcg_state_q;
    bound_d     = bound_q;
    second_d    = second_q;
    hi_d        = hi_q;
    u_d         = u_q;
    res_val_d   = res_val_q;
    res_bad_d   = res_bad_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    mac_req.start   = 1'b0;
    mac_req.sel_inv = 1'b0;
    mac_req.a       = lcg_state_q;
    mac_req.addend  = lcg48_pkg::LCG_ADD;

    rem_req.start    = 1'b0;
    rem_req.dividend = draw31;
    rem_req.divisor  = bound_q;

    // A waiting result leaves the output register once it is taken.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d     = in_item_i.command;
          bound_d   = in_item_i.bound[RW-1:0];
          second_d  = 1'b0;
          res_val_d = '0;
          res_bad_d = 1'b0;
          case (in_item_i.command)
            lcg48_pkg::CMD_RESEED: begin
              lcg_state_d = in_item_i.seed_value[SW-1:0] ^ lcg48_pkg::LCG_MUL;
              state_d     = S_OUT;
            end
            lcg48_pkg::CMD_BOUNDED: begin
              // A bound of zero or less is flagged and leaves the state alone.
              if (in_item_i.bound[31] || in_item_i.bound == '0) begin
                res_bad_d = 1'b1;
                state_d   = S_OUT;
              end else begin
                mac_req.start = 1'b1;
                state_d       = S_MUL;
              end
            end
            lcg48_pkg::CMD_FWD: begin
              mac_req.start = 1'b1;
              mac_req.a     = in_item_i.seed_value[SW-1:0];
              state_d       = S_MUL;
            end
            lcg48_pkg::CMD_INV: begin
              mac_req.start   = 1'b1;
              mac_req.sel_inv = 1'b1;
              mac_req.a       = in_item_i.seed_value[SW-1:0] - lcg48_pkg::LCG_ADD;
              mac_req.addend  = '0;
              state_d         = S_MUL;
            end
            default: begin
              mac_req.start = 1'b1;
              state_d       = S_MUL;
            end
          endcase
        end
      end

      S_MUL: begin
        if (mac_rsp.done) begin
          if (cmd_q == lcg48_pkg::CMD_FWD || cmd_q == lcg48_pkg::CMD_INV) begin
            // Pure step commands report the product and keep the state.
            res_val_d = 64'(step);
            state_d   = S_OUT;
          end else begin
            lcg_state_d = step;
            state_d     = S_OUT;
            case (cmd_q)
              lcg48_pkg::CMD_INT: begin
                res_val_d = {{32{step[SW-1]}}, step[SW-1:SW-32]};
              end
              lcg48_pkg::CMD_FLOAT: begin
                res_val_d = 64'(step[SW-1:SW-24]);
              end
              lcg48_pkg::CMD_LONG: begin
                if (!second_q) begin
                  hi_d          = step[SW-1:SW-32];
                  second_d      = 1'b1;
                  mac_req.start = 1'b1;
                  mac_req.a     = step;
                  state_d       = S_MUL;
                end else begin
                  res_val_d = {hi_q, 32'd0} + {{32{step[SW-1]}}, step[SW-1:SW-32]};
                end
              end
              lcg48_pkg::CMD_DOUBLE: begin
                if (!second_q) begin
                  hi_d          = 32'(step[SW-1:SW-26]);
                  second_d      = 1'b1;
                  mac_req.start = 1'b1;
                  mac_req.a     = step;
                  state_d       = S_MUL;
                end else begin
                  res_val_d = 64'({hi_q[25:0], 27'd0}) + 64'(step[SW-1:SW-27]);
                end
              end
              lcg48_pkg::CMD_BOUNDED: begin
                if (bound_pow2) begin
                  res_val_d = 64'(draw31 >> pow2_shift);
                end else begin
                  u_d           = draw31;
                  rem_req.start = 1'b1;
                  state_d       = S_DIV;
                end
              end
              default: begin
                res_val_d = '0;
              end
            endcase
          end
        end
      end

      S_DIV: begin
        if (rem_rsp.done) begin
          if (reject_chk[31]) begin
            // Draw rejected: advance the (already updated) state once more.
            mac_req.start = 1'b1;
            state_d       = S_MUL;
          end else begin
            res_val_d = 64'(rem_rsp.remainder);
            state_d   = S_OUT;
          end
        end
      end

      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.value     = res_val_q;
          out_d.bad_bound = res_bad_q;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lcg_state_q <= '0;
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      lcg_state_q <= lcg_state_d;
      out_valid_q <= out_valid_d;
      second_q    <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    bound_q   <= bound_d;
    hi_q      <= hi_d;
    u_q       <= u_d;
    res_val_q <= res_val_d;
    res_bad_q <= res_bad_d;
    out_q     <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTH
  // The multiply unit only finishes while the sequencer waits for it.
  a_mac_done_in_mul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_rsp.done |-> state_q == S_MUL)
    else $error("multiply result arrived outside the multiply wait");

  // The remainder unit only finishes while the sequencer waits for it.
  a_rem_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_rsp.done |-> state_q == S_DIV)
    else $error("remainder result arrived outside the divide wait");

  // The pure step commands never disturb the generator state.
  a_pure_keeps_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL && (cmd_q == lcg48_pkg::CMD_FWD || cmd_q == lcg48_pkg::CMD_INV))
    |=> $stable(lcg_state_q))
    else $error("pure step command changed the generator state");
`endif

endmodule

// ===== tb/sv/tb_lcg48_random_generator_top.sv =====
// ----------------------------------------------------------------------------
// tb_lcg48_random_generator_top
// Self-checking testbench for the 48-bit linear congruential generator.
// ----------------------------------------------------------------------------
// Command items are driven on the input channel and every accepted item is
// run through a local model of the generator, which keeps its own copy of
// the 48-bit state. The model's result is queued, and each result item taken
// from the output channel is checked field by field against the oldest entry
// in the queue. A directed part covers the state after reset, seed extremes,
// the invalid and special bounds and the pure step commands. A long random
// part follows, first with random idling on both channels and then as an
// unbroken burst. A watchdog ends the run if the channels stop moving.
// ----------------------------------------------------------------------------
module tb_lcg48_random_generator_top;

  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned IDLE_PERCENT   = 15;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  // Longest single attempt is a bounded draw with a remainder of 31 steps.
  localparam int unsigned DRAIN_CYCLES   = 100;
  localparam int unsigned MIXED_ITEMS    = 1000;
  localparam int unsigned BURST_ITEMS    = 230;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  lcg48_pkg::in_item_t  in_item_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  lcg48_pkg::out_item_t out_item_o;

  // Model state: the generator's 48-bit state and the multiplier's inverse.
  logic [lcg48_pkg::STATE_W-1:0] model_state;
  logic [lcg48_pkg::STATE_W-1:0] mul_inverse;

  // Results that the model has worked out and the block still owes.
  lcg48_pkg::out_item_t pending_results[$];

  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idling = 1'b0;

  lcg48_random_generator_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Local model of the generator.
  // ---------------------------------------------------------------------------

  // One forward step of the recurrence. The product is taken modulo 2^64 over
  // the whole operand and then cut to 48 bits, so wide values behave as the
  // pure step command expects.
  function automatic logic [lcg48_pkg::STATE_W-1:0] lcg_forward(logic [63:0] s);
    logic [63:0] p;
    p = s * 64'(lcg48_pkg::LCG_MUL) + 64'(lcg48_pkg::LCG_ADD);
    return p[lcg48_pkg::STATE_W-1:0];
  endfunction

  // Advances the model state and returns its top nbits bits.
  function automatic logic [31:0] draw_bits(int unsigned nbits);
    model_state = lcg_forward({16'd0, model_state});
    return 32'(model_state >> (lcg48_pkg::STATE_W - nbits));
  endfunction

  function automatic logic [63:0] widen_signed(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // Works out the result item that the block owes for one command item and
  // updates the model state on the way.
  function automatic lcg48_pkg::out_item_t next_random_result(lcg48_pkg::in_item_t it);
    lcg48_pkg::out_item_t res;
    logic [63:0]          seed;
    logic [63:0]          hi;
    logic [63:0]          lo;
    logic [63:0]          prod;
    logic [31:0]          b;
    logic [31:0]          m;
    logic [31:0]          u;
    logic [31:0]          r;
    logic [31:0]          t;
    seed          = it.seed_value;
    b             = it.bound;
    res.value     = '0;
    res.bad_bound = 1'b0;
    case (it.command)
      lcg48_pkg::CMD_RESEED: begin
        prod        = seed ^ 64'(lcg48_pkg::LCG_MUL);
        model_state = prod[lcg48_pkg::STATE_W-1:0];
      end
      lcg48_pkg::CMD_INT: begin
        res.value = widen_signed(draw_bits(32));
      end
      lcg48_pkg::CMD_LONG: begin
        hi        = widen_signed(draw_bits(32));
        lo        = widen_signed(draw_bits(32));
        res.value = (hi << 32) + lo;
      end
      lcg48_pkg::CMD_BOUNDED: begin
        // A bound of zero or less is flagged and leaves the state alone.
        if (b == 32'd0 || b[31]) begin
          res.bad_bound = 1'b1;
        end else begin
          m = b - 32'd1;
          r = draw_bits(31);
          if ((b & m) == 32'd0) begin
            prod = (64'(b) * 64'(r)) >> 31;
            r    = prod[31:0];
          end else begin
            // Modulo with rejection of the uneven tail of the draw range.
            u = r;
            r = u % b;
            t = u - r + m;
            while (t[31]) begin
              u = draw_bits(31);
              r = u % b;
              t = u - r + m;
            end
          end
          res.value = 64'(r);
        end
      end
      lcg48_pkg::CMD_FLOAT: begin
        res.value = 64'(draw_bits(24));
      end
      lcg48_pkg::CMD_DOUBLE: begin
        hi        = 64'(draw_bits(26));
        lo        = 64'(draw_bits(27));
        res.value = (hi << 27) + lo;
      end
      lcg48_pkg::CMD_FWD: begin
        res.value = 64'(lcg_forward(seed));
      end
      default: begin
        prod      = (seed - 64'(lcg48_pkg::LCG_ADD)) * 64'(mul_inverse);
        res.value = 64'(prod[lcg48_pkg::STATE_W-1:0]);
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel driving. Inputs change on the falling edge only.
  // ---------------------------------------------------------------------------

  function automatic bit take_a_break();
    return !no_idling && ($urandom_range(99) < IDLE_PERCENT);
  endfunction

  // The receiver stalls at random, except during the burst.
  always @(negedge clk_i) begin
    out_stall_i <= take_a_break();
  end

  // Sends one command item. It is entered on a falling edge and returns on
  // the falling edge after the item was accepted, so that a following item
  // keeps valid high without a second assignment in the same step.
  task automatic send_item(lcg48_pkg::cmd_e cmd, logic [63:0] seed, logic [31:0] bnd);
    lcg48_pkg::in_item_t it;
    it.command    = cmd;
    it.seed_value = seed;
    it.bound      = bnd;
    while (take_a_break()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    pending_results.push_back(next_random_result(it));
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and the watchdog.
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    lcg48_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result item with nothing expected, value %h",
                                  out_item_o.value));
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.value !== want.value) begin
          report_mismatch($sformatf("value %h, expected %h",
                                    out_item_o.value, want.value));
        end
        if (out_item_o.bad_bound !== want.bad_bound) begin
          report_mismatch($sformatf("bad_bound %b, expected %b",
                                    out_item_o.bad_bound, want.bad_bound));
        end
      end
    end
  end

  // Counts cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles.", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Random field values, weighted towards the interesting corners.
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] pick_seed();
    case ($urandom_range(9))
      0:       return 64'd0;
      1:       return '1;
      2:       return 64'h8000_0000_0000_0000;
      3:       return 64'h7FFF_FFFF_FFFF_FFFF;
      4:       return 64'($urandom_range(255));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [31:0] pick_bound();
    case ($urandom_range(11))
      0:       return 32'd0;
      1:       return $urandom() | 32'h8000_0000;
      2:       return 32'd1 << $urandom_range(30);
      3:       return 32'($urandom_range(16, 1));
      4:       return 32'h7FFF_FFFF - 32'($urandom_range(1000));
      5:       return 32'h4000_0001 + 32'($urandom_range(1000));
      6:       return $urandom();
      default: return 32'($urandom_range(100000, 1));
    endcase
  endfunction

  task automatic send_random_items(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_item(lcg48_pkg::cmd_e'($urandom_range(7)), pick_seed(), pick_bound());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // The state is zero straight after reset, so the first draws come from it.
  task automatic test_draws_after_reset();
    send_item(lcg48_pkg::CMD_INT, '0, '0);
    send_item(lcg48_pkg::CMD_FLOAT, '0, '0);
  endtask

  // Seeds at their extremes; the first two are followed by a long and a double draw.
  task automatic test_reseed_extremes();
    send_item(lcg48_pkg::CMD_RESEED, 64'd0, '0);
    send_item(lcg48_pkg::CMD_LONG, '0, '0);
    send_item(lcg48_pkg::CMD_RESEED, '1, '0);
    send_item(lcg48_pkg::CMD_DOUBLE, '0, '0);
    send_item(lcg48_pkg::CMD_RESEED, 64'h8000_0000_0000_0000, 32'h8000_0000);
    send_item(lcg48_pkg::CMD_RESEED, 64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF);
    send_item(lcg48_pkg::CMD_INT, '1, '1);
  endtask

  // Zero and negative bounds must be flagged without advancing the state;
  // a bound of one, a power of two, the largest bound and a small odd bound
  // cover the scaled multiply and the rejection path.
  task automatic test_bound_edges();
    send_item(lcg48_pkg::CMD_BOUNDED, '0, 32'd0);
    send_item(lcg48_pkg::CMD_BOUNDED, '0, '1);
    send_item(lcg48_pkg::CMD_BOUNDED, '1, 32'h8000_0000);
    send_item(lcg48_pkg::CMD_BOUNDED, '0, 32'd1);
    send_item(lcg48_pkg::CMD_BOUNDED, '0, 32'h4000_0000);
    send_item(lcg48_pkg::CMD_BOUNDED, '0, 32'h7FFF_FFFF);
    send_item(lcg48_pkg::CMD_BOUNDED, '0, 32'd3);
  endtask

  // Pure steps use the low 48 bits of the operand only. The draw afterwards shows
  // that they left the state alone.
  task automatic test_pure_steps();
    send_item(lcg48_pkg::CMD_FWD, '1, '0);
    send_item(lcg48_pkg::CMD_FWD, 64'h8000_0000_0000_0000, '0);
    send_item(lcg48_pkg::CMD_INV, 64'd0, '0);
    send_item(lcg48_pkg::CMD_INV, 64'h7FFF_FFFF_FFFF_FFFF, '1);
    send_item(lcg48_pkg::CMD_INV, '1, '0);
    send_item(lcg48_pkg::CMD_INT, '0, '0);
  endtask

  // Random commands with idling on both channels.
  task automatic test_random_mix();
    send_random_items(MIXED_ITEMS);
  endtask

  // Random commands back to back, with neither side ever idling.
  task automatic test_unbroken_burst();
    no_idling = 1'b1;
    send_random_items(BURST_ITEMS);
    no_idling = 1'b0;
  endtask

  initial begin
    logic [lcg48_pkg::STATE_W-1:0] x;
    logic [lcg48_pkg::STATE_W-1:0] chk;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    model_state = '0;

    // The multiplier is odd, so Newton steps from itself converge on its
    // inverse modulo 2^48, doubling the correct low bits each time.
    x   = lcg48_pkg::LCG_MUL;
    chk = lcg48_pkg::LCG_MUL * x;
    while (chk != 48'd1) begin
      x   = x * (48'd2 - lcg48_pkg::LCG_MUL * x);
      chk = lcg48_pkg::LCG_MUL * x;
    end
    mul_inverse = x;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_draws_after_reset();
    test_reseed_extremes();
    test_bound_edges();
    test_pure_steps();
    test_random_mix();
    test_unbroken_burst();

    in_valid_i <= 1'b0;
    // The watchdog bounds this wait should the block stop answering.
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/lcg48_pkg.sv
sv/lcg48_mac.sv
sv/lcg48_rem.sv
sv/lcg48_random_generator_top.sv
tb/sv/tb_lcg48_random_generator_top.sv
